// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the polyline corner filter
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in a cycle, consequent must hold in the same cycle
`define ASSERT_IMPLIES(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle, consequent must hold in the next cycle
`define ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcf_pkg.sv =====
// types, widths and codes of the polyline corner filter
// no dependencies
package pcf_pkg;

    // coordinate and derived widths
    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int LIMB_W     = DIFF_W;
    localparam int MUL_W      = LIMB_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int LEN_W      = 2 * COORD_BITS + 2;
    localparam int DOT_W      = 2 * COORD_BITS + 3;
    localparam int COS_W      = 17;
    localparam int MINLEN_W   = 35;
    localparam int CSQ_W      = 2 * COS_W;
    localparam int LP_W       = 2 * LEN_W;
    localparam int RHS_W      = LP_W + CSQ_W;
    localparam int LHS_SHIFT  = 32;
    localparam int LHS_W      = LP_W + LHS_SHIFT;
    localparam int ACC_W      = RHS_W;
    localparam int CMP_W      = (LEN_W > MINLEN_W) ? LEN_W : MINLEN_W;

    // limb counts of the operands of the wide products
    localparam int COS_LIMBS  = (COS_W + LIMB_W - 1) / LIMB_W;
    localparam int CSQ_LIMBS  = (CSQ_W + LIMB_W - 1) / LIMB_W;
    localparam int LEN_LIMBS  = (LEN_W + LIMB_W - 1) / LIMB_W;
    localparam int LP_LIMBS   = 2 * LEN_LIMBS;
    localparam int MAX_LIMBS  = (CSQ_LIMBS > LP_LIMBS) ? CSQ_LIMBS : LP_LIMBS;
    localparam int LIMB_CNT_W = $clog2(MAX_LIMBS);
    localparam int POS_W      = $clog2(2 * MAX_LIMBS - 1);
    localparam int OPA_W      = LP_LIMBS * LIMB_W;
    localparam int OPB_W      = MAX_LIMBS * LIMB_W;

    // square and dot product steps
    localparam int SQ_STEPS   = 9;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 1'b1;

    localparam logic [COS_W-1:0]    COS_RESET    = 17'd65287;
    localparam logic [MINLEN_W-1:0] MINLEN_RESET = 35'd1;

    // points seen in the current line, saturating
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        logic                         line_start;
    } pt_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic signed [COORD_BITS-1:0] qz;
        logic                         is_first;
    } kept_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_SQ_DRAIN,
        S_CHECK,
        S_MUL,
        S_MUL_DRAIN,
        S_NEXT,
        S_EMIT
    } pcf_state_t;

    // destination of a registered product
    typedef enum logic [1:0] {
        DST_LA,
        DST_LB,
        DST_DOT,
        DST_ACC
    } pcf_dst_t;

    // wide product in progress
    typedef enum logic [1:0] {
        OP_CSQ,
        OP_LP,
        OP_RHS,
        OP_DSQ
    } pcf_op_t;

endpackage

// ===== rtl/polyline_corner_filter_top.sv =====
// polyline corner filter: angle based decimation of 3d polylines, one 18x18 multiplier
// depends on pcf_pkg and assert_macros.svh
// line start: the point is queued for output in S_EMIT before the next point is taken
// second point: taken in S_IDLE; corner: S_DIFF, S_SQ, S_SQ_DRAIN and S_CHECK, then dropped with a short segment,
// kept at once with an obtuse turn, else decided after the wide products; emits wait on kept_stall
// reset (rst_n low, asynchronous): no line open, thresholds back to defaults, output empty
module polyline_corner_filter_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pt_valid,
    output logic                                 pt_stall,
    input  pcf_pkg::pt_item_t                    pt_data,
    output logic                                 kept_valid,
    input  logic                                 kept_stall,
    output pcf_pkg::kept_item_t                  kept_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pcf_pkg::MINLEN_W-1:0]         cfg_data
);
    import pcf_pkg::*;

    `include "assert_macros.svh"

    localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(SQ_STEPS - 1);

    // control state
    pcf_state_t                state_reg, state_next;
    logic [1:0]                seen_reg;
    logic [SQ_CNT_W-1:0]       sq_cnt_reg;
    logic [LIMB_CNT_W-1:0]     i_reg, j_reg, na_reg, nb_reg;
    pcf_op_t                   op_reg;
    logic                      prod_vld_reg;
    logic                      kept_valid_reg;

    // configuration
    logic [COS_W-1:0]          cth_reg;
    logic [MINLEN_W-1:0]       minlen_reg;

    // points
    point_t                    older_reg, middle_reg, np_reg;
    kept_item_t                cand_reg;
    kept_item_t                kept_data_reg;

    // datapath
    logic signed [DIFF_W-1:0]  ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [LEN_W-1:0]          la_reg, lb_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [CSQ_W-1:0]          csq_reg;
    logic [RHS_W-1:0]          rhs_reg;
    logic [OPA_W-1:0]          opa_reg;
    logic [OPB_W-1:0]          opb_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    pcf_dst_t                  prod_dst_reg;
    logic [POS_W-1:0]          prod_pos_reg;

    // control strobes
    logic                      pt_take;
    logic                      emit_ready;
    logic                      retire;
    logic                      keep;
    logic                      too_short;
    logic                      issue;
    logic [LHS_W-1:0]          lhs;

    // sequencer conditions watched by the checks
    logic                      mul_phase;
    logic                      first_take;
    logic                      first_queued;

    // shared multiplier
    logic [LIMB_W-1:0]         limb_a, limb_b;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    pcf_dst_t                  dst;

    assign pt_stall   = (state_reg != S_IDLE);
    assign pt_take    = pt_valid && (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign kept_valid = kept_valid_reg;
    assign kept_data  = kept_data_reg;
    assign emit_ready = !kept_valid_reg || !kept_stall;
    assign issue      = (state_reg == S_SQ) || (state_reg == S_MUL);

    assign too_short = (CMP_W'(la_reg) < CMP_W'(minlen_reg))
                    || (CMP_W'(lb_reg) < CMP_W'(minlen_reg));
    assign lhs = {acc_reg[LP_W-1:0], {LHS_SHIFT{1'b0}}};

    assign mul_phase    = (state_reg == S_SQ) || (state_reg == S_SQ_DRAIN)
                       || (state_reg == S_MUL) || (state_reg == S_MUL_DRAIN);
    assign first_take   = pt_take && pt_data.line_start;
    assign first_queued = (state_reg == S_EMIT) && cand_reg.is_first && (seen_reg == SEEN_ONE);

    // next state and sequencer strobes
    always_comb
    begin
        state_next = state_reg;
        retire     = 1'b0;
        keep       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pt_valid)
                begin
                    if (pt_data.line_start)
                        state_next = S_EMIT;
                    else if (seen_reg == SEEN_TWO)
                        state_next = S_DIFF;
                end
            end
            S_DIFF:
                state_next = S_SQ;
            S_SQ:
            begin
                if (sq_cnt_reg == SQ_LAST)
                    state_next = S_SQ_DRAIN;
            end
            S_SQ_DRAIN:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (too_short)
                begin
                    retire     = 1'b1;
                    state_next = S_IDLE;
                end
                else if (dot_reg[DOT_W-1])
                begin
                    retire     = 1'b1;
                    keep       = 1'b1;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if ((i_reg == na_reg) && (j_reg == nb_reg))
                    state_next = S_MUL_DRAIN;
            end
            S_MUL_DRAIN:
                state_next = S_NEXT;
            S_NEXT:
            begin
                if (op_reg == OP_DSQ)
                begin
                    retire     = 1'b1;
                    keep       = (RHS_W'(lhs) < rhs_reg);
                    state_next = keep ? S_EMIT : S_IDLE;
                end
                else
                    state_next = S_MUL;
            end
            S_EMIT:
            begin
                if (emit_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // multiplier operand selection
    always_comb
    begin
        limb_a = LIMB_W'(opa_reg >> (i_reg * LIMB_W));
        limb_b = LIMB_W'(opb_reg >> (j_reg * LIMB_W));
        mul_a  = signed'({1'b0, limb_a});
        mul_b  = signed'({1'b0, limb_b});
        dst    = DST_ACC;
        if (state_reg == S_SQ)
        begin
            case (sq_cnt_reg)
                4'd0:    begin mul_a = MUL_W'(ax_reg); mul_b = MUL_W'(ax_reg); dst = DST_LA;  end
                4'd1:    begin mul_a = MUL_W'(ay_reg); mul_b = MUL_W'(ay_reg); dst = DST_LA;  end
                4'd2:    begin mul_a = MUL_W'(az_reg); mul_b = MUL_W'(az_reg); dst = DST_LA;  end
                4'd3:    begin mul_a = MUL_W'(bx_reg); mul_b = MUL_W'(bx_reg); dst = DST_LB;  end
                4'd4:    begin mul_a = MUL_W'(by_reg); mul_b = MUL_W'(by_reg); dst = DST_LB;  end
                4'd5:    begin mul_a = MUL_W'(bz_reg); mul_b = MUL_W'(bz_reg); dst = DST_LB;  end
                4'd6:    begin mul_a = MUL_W'(ax_reg); mul_b = MUL_W'(bx_reg); dst = DST_DOT; end
                4'd7:    begin mul_a = MUL_W'(ay_reg); mul_b = MUL_W'(by_reg); dst = DST_DOT; end
                default: begin mul_a = MUL_W'(az_reg); mul_b = MUL_W'(bz_reg); dst = DST_DOT; end
            endcase
        end
        prod = mul_a * mul_b;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // line tracking, configuration, sequencer counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= SEEN_NONE;
            older_reg      <= '0;
            middle_reg     <= '0;
            sq_cnt_reg     <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            na_reg         <= '0;
            nb_reg         <= '0;
            op_reg         <= OP_CSQ;
            prod_vld_reg   <= 1'b0;
            kept_valid_reg <= 1'b0;
            cth_reg        <= COS_RESET;
            minlen_reg     <= MINLEN_RESET;
        end
        else
        begin
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_COS:     cth_reg    <= cfg_data[COS_W-1:0];
                    CFG_MIN_LEN: minlen_reg <= cfg_data;
                    default:     ;
                endcase
            end

            // point history on a transfer
            if (pt_take)
            begin
                if (pt_data.line_start)
                begin
                    middle_reg <= '{x: pt_data.px, y: pt_data.py, z: pt_data.pz};
                    seen_reg   <= SEEN_ONE;
                end
                else if (seen_reg == SEEN_ONE)
                begin
                    older_reg  <= middle_reg;
                    middle_reg <= '{x: pt_data.px, y: pt_data.py, z: pt_data.pz};
                    seen_reg   <= SEEN_TWO;
                end
            end

            // corner decided: shift the window
            if (retire)
            begin
                older_reg  <= middle_reg;
                middle_reg <= np_reg;
            end

            // square and dot step counter
            if (state_reg == S_DIFF)
                sq_cnt_reg <= '0;
            else if (state_reg == S_SQ)
                sq_cnt_reg <= sq_cnt_reg + 1'b1;

            // limb walk of the wide products
            if ((state_reg == S_CHECK) && (state_next == S_MUL))
            begin
                i_reg  <= '0;
                j_reg  <= '0;
                na_reg <= LIMB_CNT_W'(COS_LIMBS - 1);
                nb_reg <= LIMB_CNT_W'(COS_LIMBS - 1);
                op_reg <= OP_CSQ;
            end
            else if ((state_reg == S_NEXT) && (state_next == S_MUL))
            begin
                i_reg <= '0;
                j_reg <= '0;
                case (op_reg)
                    OP_CSQ:
                    begin
                        na_reg <= LIMB_CNT_W'(LEN_LIMBS - 1);
                        nb_reg <= LIMB_CNT_W'(LEN_LIMBS - 1);
                        op_reg <= OP_LP;
                    end
                    OP_LP:
                    begin
                        na_reg <= LIMB_CNT_W'(LP_LIMBS - 1);
                        nb_reg <= LIMB_CNT_W'(CSQ_LIMBS - 1);
                        op_reg <= OP_RHS;
                    end
                    default:
                    begin
                        na_reg <= LIMB_CNT_W'(LEN_LIMBS - 1);
                        nb_reg <= LIMB_CNT_W'(LEN_LIMBS - 1);
                        op_reg <= OP_DSQ;
                    end
                endcase
            end
            else if (state_reg == S_MUL)
            begin
                if (i_reg == na_reg)
                begin
                    i_reg <= '0;
                    j_reg <= j_reg + 1'b1;
                end
                else
                    i_reg <= i_reg + 1'b1;
            end

            prod_vld_reg <= issue;

            // output register
            if ((state_reg == S_EMIT) && emit_ready)
                kept_valid_reg <= 1'b1;
            else if (!kept_stall)
                kept_valid_reg <= 1'b0;
        end
    end

    // payload and arithmetic registers
    always_ff @(posedge clk)
    begin
        // incoming point and pending result
        if (pt_take)
        begin
            np_reg <= '{x: pt_data.px, y: pt_data.py, z: pt_data.pz};
            if (pt_data.line_start)
                cand_reg <= '{qx: pt_data.px, qy: pt_data.py, qz: pt_data.pz, is_first: 1'b1};
        end
        if (retire)
            cand_reg <= '{qx: middle_reg.x, qy: middle_reg.y, qz: middle_reg.z, is_first: 1'b0};

        if ((state_reg == S_EMIT) && emit_ready)
            kept_data_reg <= cand_reg;

        // segment vectors
        if (state_reg == S_DIFF)
        begin
            ax_reg <= DIFF_W'(middle_reg.x) - DIFF_W'(older_reg.x);
            ay_reg <= DIFF_W'(middle_reg.y) - DIFF_W'(older_reg.y);
            az_reg <= DIFF_W'(middle_reg.z) - DIFF_W'(older_reg.z);
            bx_reg <= DIFF_W'(np_reg.x) - DIFF_W'(middle_reg.x);
            by_reg <= DIFF_W'(np_reg.y) - DIFF_W'(middle_reg.y);
            bz_reg <= DIFF_W'(np_reg.z) - DIFF_W'(middle_reg.z);
            la_reg  <= '0;
            lb_reg  <= '0;
            dot_reg <= '0;
        end

        // product register behind the multiplier
        if (issue)
        begin
            prod_reg     <= prod;
            prod_dst_reg <= dst;
            prod_pos_reg <= POS_W'(i_reg) + POS_W'(j_reg);
        end

        // accumulate the registered product
        if (prod_vld_reg)
        begin
            case (prod_dst_reg)
                DST_LA:  la_reg  <= la_reg + prod_reg[LEN_W-1:0];
                DST_LB:  lb_reg  <= lb_reg + prod_reg[LEN_W-1:0];
                DST_DOT: dot_reg <= dot_reg + signed'(prod_reg[DOT_W-1:0]);
                default: acc_reg <= acc_reg
                                  + (ACC_W'(prod_reg[2*LIMB_W-1:0]) << (prod_pos_reg * LIMB_W));
            endcase
        end

        // operand loads for the next wide product
        if ((state_reg == S_CHECK) && (state_next == S_MUL))
        begin
            opa_reg <= OPA_W'(cth_reg);
            opb_reg <= OPB_W'(cth_reg);
            acc_reg <= '0;
        end
        else if ((state_reg == S_NEXT) && (state_next == S_MUL))
        begin
            acc_reg <= '0;
            case (op_reg)
                OP_CSQ:
                begin
                    csq_reg <= acc_reg[CSQ_W-1:0];
                    opa_reg <= OPA_W'(la_reg);
                    opb_reg <= OPB_W'(lb_reg);
                end
                OP_LP:
                begin
                    opa_reg <= acc_reg[OPA_W-1:0];
                    opb_reg <= OPB_W'(csq_reg);
                end
                default:
                begin
                    rhs_reg <= acc_reg;
                    opa_reg <= OPA_W'(dot_reg[LEN_W-1:0]);
                    opb_reg <= OPB_W'(dot_reg[LEN_W-1:0]);
                end
            endcase
        end
    end

    // checks on the sequencer
    `ASSERT_IMPLIES(a_prod_in_compute, clk, rst_n, prod_vld_reg, mul_phase, "product pending outside a multiply phase")
    `ASSERT_IMPLIES(a_check_two_points, clk, rst_n, state_reg == S_CHECK, seen_reg == SEEN_TWO, "corner test without two earlier points")
    `ASSERT_NEXT(a_first_sets_one, clk, rst_n, first_take, first_queued, "line start not queued as first point")

endmodule

// ===== verif/polyline_corner_filter_top_test.sv =====
`timescale 1ns / 100ps
// testbench for polyline_corner_filter_top: a directed table then random polylines,
// with each result checked against a typed table row or a behavioural corner filter in this file
// depends on pcf_pkg and the rtl of polyline_corner_filter_top
module polyline_corner_filter_top_test;
    import pcf_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_HOLD = 400;
    localparam int N_DIR = 21;

    // one row of the directed table; typed rows carry their expected result
    typedef struct {
        int x;
        int y;
        int z;
        bit start;
        bit typed;
        bit has_res;
        int ex;
        int ey;
        int ez;
        bit efirst;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic pt_valid;
    logic pt_stall;
    pt_item_t pt_data;
    logic kept_valid;
    logic kept_stall;
    kept_item_t kept_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MINLEN_W-1:0] cfg_data;

    // behavioural copy of the filter state and thresholds
    point_t prev_pt;
    point_t mid_pt;
    logic [1:0] line_pts;
    logic [COS_W-1:0] cos_limit;
    logic [MINLEN_W-1:0] min_seg_sq;

    kept_item_t kept_expect_q[$];
    int err_cnt;
    int shown_cnt;
    int cycle_cnt;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int hold_left;

    dir_row_t dir_table [0:N_DIR-1] = '{
        // point before any line start is ignored
        '{100, 200, 300, 0, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 1, 1, 1, 0, 0, 0, 1},
        '{100, 0, 0, 0, 1, 0, 0, 0, 0, 0},
        // straight, right angle, reversal, zero length segments
        '{200, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{200, 100, 0, 0, 0, 0, 0, 0, 0, 0},
        '{100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{100, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // new line while a point is pending, coordinate extremes
        '{-32768, -32768, -32768, 1, 1, 1, -32768, -32768, -32768, 1},
        '{32767, 32767, 32767, 0, 1, 0, 0, 0, 0, 0},
        '{-32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0},
        '{32767, -32768, 32767, 0, 0, 0, 0, 0, 0, 0},
        '{32767, 32767, -32768, 0, 0, 0, 0, 0, 0, 0},
        '{-32768, 32767, 32767, 1, 1, 1, -32768, 32767, 32767, 1},
        '{-32767, 32767, 32767, 0, 1, 0, 0, 0, 0, 0},
        '{-32766, 32767, 32767, 0, 0, 0, 0, 0, 0, 0},
        '{-32765, 32766, 32767, 0, 0, 0, 0, 0, 0, 0},
        // line of a single point followed by another line
        '{5, 5, 5, 1, 1, 1, 5, 5, 5, 1},
        '{7, 7, 7, 1, 1, 1, 7, 7, 7, 1},
        '{7, 7, 7, 0, 1, 0, 0, 0, 0, 0},
        '{7, 7, 7, 0, 0, 0, 0, 0, 0, 0}
    };

    polyline_corner_filter_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_valid   (pt_valid),
        .pt_stall   (pt_stall),
        .pt_data    (pt_data),
        .kept_valid (kept_valid),
        .kept_stall (kept_stall),
        .kept_data  (kept_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // exact turn test: a short segment drops, a negative dot keeps, else dot^2 * 2^32 against cos^2 * |a|^2 * |b|^2
    function automatic bit corner_is_sharp(point_t o, point_t m, point_t n);
        longint ax, ay, az, bx, by, bz, dot;
        logic [127:0] len_a, len_b, dot_w, cos_w, lhs, rhs;
        ax = longint'(m.x) - longint'(o.x);
        ay = longint'(m.y) - longint'(o.y);
        az = longint'(m.z) - longint'(o.z);
        bx = longint'(n.x) - longint'(m.x);
        by = longint'(n.y) - longint'(m.y);
        bz = longint'(n.z) - longint'(m.z);
        len_a = ax * ax + ay * ay + az * az;
        len_b = bx * bx + by * by + bz * bz;
        dot = ax * bx + ay * by + az * bz;
        if (len_a < min_seg_sq || len_b < min_seg_sq)
            return 1'b0;
        if (dot < 0)
            return 1'b1;
        dot_w = dot;
        cos_w = cos_limit;
        lhs = (dot_w * dot_w) << 32;
        rhs = cos_w * cos_w * len_a * len_b;
        return lhs < rhs;
    endfunction

    // advance the filter by one point; returns 1 when a point is emitted
    function automatic bit filter_point(input pt_item_t it, output kept_item_t res);
        point_t p;
        bit keep;
        p.x = it.px;
        p.y = it.py;
        p.z = it.pz;
        res = '0;
        if (it.line_start)
        begin
            mid_pt = p;
            line_pts = SEEN_ONE;
            res.qx = it.px;
            res.qy = it.py;
            res.qz = it.pz;
            res.is_first = 1'b1;
            return 1'b1;
        end
        if (line_pts == SEEN_NONE)
            return 1'b0;
        if (line_pts == SEEN_ONE)
        begin
            prev_pt = mid_pt;
            mid_pt = p;
            line_pts = SEEN_TWO;
            return 1'b0;
        end
        keep = corner_is_sharp(prev_pt, mid_pt, p);
        res.qx = mid_pt.x;
        res.qy = mid_pt.y;
        res.qz = mid_pt.z;
        res.is_first = 1'b0;
        prev_pt = mid_pt;
        mid_pt = p;
        return keep;
    endfunction

    // offer one point, wait for its transfer, then queue what it should produce
    task automatic offer_point(input pt_item_t it, input bit typed, input bit typed_has,
                               input kept_item_t typed_res);
        kept_item_t res;
        bit has;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pt_valid <= 1'b0;
            @(posedge clk);
        end
        pt_valid <= 1'b1;
        pt_data <= it;
        do
            @(posedge clk);
        while (pt_stall);
        has = filter_point(it, res);
        if (typed)
        begin
            has = typed_has;
            res = typed_res;
        end
        if (has)
            kept_expect_q.insert(kept_expect_q.size(), res);
    endtask

    // stop offering until every expected result is out, then let the block go idle
    task automatic wait_drained();
        pt_valid <= 1'b0;
        do
            @(posedge clk);
        while (kept_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MINLEN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_COS)
            cos_limit = val[COS_W-1:0];
        else
            min_seg_sq = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random polylines: mostly nearly straight walks at varied scales, some noise points
    task automatic send_polylines(input int n_items);
        int sent, npts, k, scale, jit, dx, dy, dz;
        logic [COORD_BITS-1:0] cx, cy, cz;
        pt_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                it.px = COORD_BITS'($urandom);
                it.py = COORD_BITS'($urandom);
                it.pz = COORD_BITS'($urandom);
                it.line_start = 1'($urandom_range(1));
                offer_point(it, 1'b0, 1'b0, '0);
                sent++;
            end
            else
            begin
                scale = 1 << $urandom_range(14);
                npts = $urandom_range(12, 2);
                cx = COORD_BITS'($urandom);
                cy = COORD_BITS'($urandom);
                cz = COORD_BITS'($urandom);
                dx = int'($urandom_range(2 * scale)) - scale;
                dy = int'($urandom_range(2 * scale)) - scale;
                dz = int'($urandom_range(2 * scale)) - scale;
                for (k = 0; k < npts; k++)
                begin
                    it.px = cx;
                    it.py = cy;
                    it.pz = cz;
                    it.line_start = (k == 0);
                    offer_point(it, 1'b0, 1'b0, '0);
                    sent++;
                    // occasional sharp turn or repeated point
                    case ($urandom_range(15))
                        0:
                        begin
                            dx = int'($urandom_range(2 * scale)) - scale;
                            dy = int'($urandom_range(2 * scale)) - scale;
                            dz = int'($urandom_range(2 * scale)) - scale;
                        end
                        1:
                            continue;
                        default: ;
                    endcase
                    jit = scale >> $urandom_range(8, 1);
                    cx = cx + COORD_BITS'(dx + int'($urandom_range(2 * jit)) - jit);
                    cy = cy + COORD_BITS'(dy + int'($urandom_range(2 * jit)) - jit);
                    cz = cz + COORD_BITS'(dz + int'($urandom_range(2 * jit)) - jit);
                end
            end
        end
    endtask

    // result side: check each transfer, stall at random or for one long hold
    initial
    begin
        kept_item_t want;
        kept_stall <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && kept_valid && !kept_stall)
            begin
                if (kept_expect_q.size() == 0)
                begin
                    err_cnt++;
                    if (shown_cnt < 10)
                    begin
                        shown_cnt++;
                        $display("unexpected result: qx=%0d qy=%0d qz=%0d is_first=%0b",
                                 kept_data.qx, kept_data.qy, kept_data.qz, kept_data.is_first);
                    end
                end
                else
                begin
                    want = kept_expect_q.pop_front();
                    if (kept_data.qx !== want.qx || kept_data.qy !== want.qy ||
                        kept_data.qz !== want.qz || kept_data.is_first !== want.is_first)
                    begin
                        err_cnt++;
                        if (shown_cnt < 10)
                        begin
                            shown_cnt++;
                            $display("mismatch: expected %0d %0d %0d first=%0b, got %0d %0d %0d first=%0b",
                                     want.qx, want.qy, want.qz, want.is_first,
                                     kept_data.qx, kept_data.qy, kept_data.qz,
                                     kept_data.is_first);
                        end
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                kept_stall <= 1'b1;
            end
            else
                kept_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        int i;
        pt_item_t it;
        kept_item_t res;
        err_cnt = 0;
        shown_cnt = 0;
        hold_req = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 54;
        cos_limit = COS_RESET;
        min_seg_sq = MINLEN_RESET;
        prev_pt = '0;
        mid_pt = '0;
        line_pts = SEEN_NONE;
        rst_n <= 1'b0;
        pt_valid <= 1'b0;
        pt_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_COS;
        cfg_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset thresholds
        for (i = 0; i < N_DIR; i++)
        begin
            it.px = COORD_BITS'(dir_table[i].x);
            it.py = COORD_BITS'(dir_table[i].y);
            it.pz = COORD_BITS'(dir_table[i].z);
            it.line_start = dir_table[i].start;
            res.qx = COORD_BITS'(dir_table[i].ex);
            res.qy = COORD_BITS'(dir_table[i].ey);
            res.qz = COORD_BITS'(dir_table[i].ez);
            res.is_first = dir_table[i].efirst;
            offer_point(it, dir_table[i].typed, dir_table[i].has_res, res);
        end

        // threshold exactly one, no minimum length; long output hold and a pause
        send_idle_pct = 34;
        recv_idle_pct = 54;
        wait_drained();
        write_reg(CFG_COS, 35'd65536);
        write_reg(CFG_MIN_LEN, 35'd0);
        send_polylines(60);
        hold_req = 1'b1;
        send_polylines(80);
        wait_drained();
        send_polylines(60);

        // nothing but line starts can pass
        wait_drained();
        write_reg(CFG_COS, 35'd0);
        write_reg(CFG_MIN_LEN, {MINLEN_W{1'b1}});
        send_polylines(60);

        // threshold above one, the other way round for idling
        send_idle_pct = 54;
        recv_idle_pct = 34;
        wait_drained();
        write_reg(CFG_COS, {COS_W{1'b1}});
        write_reg(CFG_MIN_LEN, 35'd1);
        send_polylines(150);

        wait_drained();
        write_reg(CFG_COS, 35'd62000);
        write_reg(CFG_MIN_LEN, 35'd400);
        send_polylines(150);

        // back to back at a mild angle
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        write_reg(CFG_COS, 35'd65000);
        write_reg(CFG_MIN_LEN, 35'd10000);
        send_polylines(270);

        wait_drained();
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
